// ===== hw/rtl/hpkb_pkg.sv =====
// Shared types, constants and codes of the HTTP path keyword blocker.
`default_nettype none

package hpkb_pkg;

  localparam int unsigned NumKeywords = 3;
  localparam int unsigned WinDepth    = 16;
  localparam int unsigned LenLimit    = 1024;
  localparam int unsigned CountW      = 10;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [3:0]        PrefixSkip = 4'd11;
  localparam logic [4:0]        MaxWordLen = 5'd16;
  localparam logic [CountW-1:0] LenCap     =
      CountW'(((LenLimit - 1) < 1023) ? (LenLimit - 1) : 1023);

  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [7:0] ByteSpace = 8'h20;

  typedef enum logic [1:0] {
    PHASE_SKIP = 2'd0,
    PHASE_HOST = 2'd1,
    PHASE_PATH = 2'd2,
    PHASE_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_ALLOWED   = 2'd0,
    VERDICT_BLOCKED   = 2'd1,
    VERDICT_MALFORMED = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    EMIT_NONE      = 2'd0,
    EMIT_VERDICT   = 2'd1,
    EMIT_MALFORMED = 2'd2
  } emit_e;

  typedef enum logic [2:0] {
    CFG_KW0_LOW  = 3'd0,
    CFG_KW0_HIGH = 3'd1,
    CFG_KW1_LOW  = 3'd2,
    CFG_KW1_HIGH = 3'd3,
    CFG_KW2_LOW  = 3'd4,
    CFG_KW2_HIGH = 3'd5,
    CFG_LENGTHS  = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic              byte_en;
    logic              first;
    logic [7:0]        data;
    emit_e             emit;
    logic [CountW-1:0] host_len;
    logic [CountW-1:0] path_len;
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hpkb_front.sv =====
// Request parser: tracks the phase and lengths and issues work to the matcher.
`default_nettype none

module hpkb_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         start_of_request_i,
  input  wire logic         end_of_request_i,
  input  wire logic         full_i,
  output logic              push_o,
  output hpkb_pkg::op_t     push_op_o
);

  hpkb_pkg::phase_e                 phase_q, phase_d;
  logic [3:0]                       prefix_q, prefix_d;
  logic [hpkb_pkg::CountW-1:0]      host_q, host_d;
  logic [hpkb_pkg::CountW-1:0]      path_q, path_d;
  logic                             accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hpkb_pkg::PHASE_SKIP;
      prefix_q <= '0;
      host_q   <= '0;
      path_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      host_q   <= host_d;
      path_q   <= path_d;
    end
  end

  always_comb begin
    hpkb_pkg::phase_e            ph;
    logic [3:0]                  pc;
    logic [hpkb_pkg::CountW-1:0] hc;
    logic [hpkb_pkg::CountW-1:0] pl;
    hpkb_pkg::op_t               op;

    ph = start_of_request_i ? hpkb_pkg::PHASE_SKIP : phase_q;
    pc = start_of_request_i ? 4'd0 : prefix_q;
    hc = start_of_request_i ? '0 : host_q;
    pl = start_of_request_i ? '0 : path_q;

    op          = '0;
    op.data     = data_byte_i;
    op.emit     = hpkb_pkg::EMIT_NONE;

    if (ph == hpkb_pkg::PHASE_SKIP) begin
      if (pc >= hpkb_pkg::PrefixSkip) begin
        ph = hpkb_pkg::PHASE_HOST;
      end else begin
        pc = pc + 4'd1;
      end
    end

    case (ph)
      hpkb_pkg::PHASE_HOST: begin
        if (data_byte_i == hpkb_pkg::ByteSlash) begin
          ph         = hpkb_pkg::PHASE_PATH;
          op.byte_en = 1'b1;
          op.first   = 1'b1;
          if (pl < hpkb_pkg::LenCap) pl = pl + 1'b1;
        end else if (hc < hpkb_pkg::LenCap) begin
          hc = hc + 1'b1;
        end
      end
      hpkb_pkg::PHASE_PATH: begin
        if (data_byte_i == hpkb_pkg::ByteSpace) begin
          ph      = hpkb_pkg::PHASE_DONE;
          op.emit = hpkb_pkg::EMIT_VERDICT;
        end else begin
          op.byte_en = 1'b1;
          if (pl < hpkb_pkg::LenCap) pl = pl + 1'b1;
        end
      end
      default: ;
    endcase

    if (end_of_request_i && ph != hpkb_pkg::PHASE_DONE) begin
      ph      = hpkb_pkg::PHASE_DONE;
      op.emit = hpkb_pkg::EMIT_MALFORMED;
    end

    op.host_len = hc;
    op.path_len = pl;

    phase_d  = phase_q;
    prefix_d = prefix_q;
    host_d   = host_q;
    path_d   = path_q;
    if (accept) begin
      phase_d  = ph;
      prefix_d = pc;
      host_d   = hc;
      path_d   = pl;
    end

    push_op_o = op;
    push_o    = accept && (op.byte_en || op.emit != hpkb_pkg::EMIT_NONE);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hpkb_queue.sv =====
// Short queue of work words between the parser and the matcher.
`default_nettype none

module hpkb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  hpkb_pkg::op_t       push_op_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output hpkb_pkg::op_t       head_op_o
);

  localparam int unsigned PtrW = (hpkb_pkg::QueueDepth > 1) ?
                                 $clog2(hpkb_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(hpkb_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(hpkb_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(hpkb_pkg::QueueDepth);

  hpkb_pkg::op_t   mem_q [hpkb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hpkb_back.sv =====
// Keyword matcher: keyword registers, path window, hit flag and result register.
`default_nettype none

module hpkb_back #(
  parameter int unsigned NUM_KEYWORDS = hpkb_pkg::NumKeywords
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [63:0]                   cfg_data_i,
  input  wire logic                          head_valid_i,
  input  hpkb_pkg::op_t                      head_op_i,
  output logic                               pop_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [1:0]                         verdict_o,
  output logic [hpkb_pkg::CountW-1:0]        host_length_o,
  output logic [hpkb_pkg::CountW-1:0]        path_length_o
);

  localparam int unsigned Depth = hpkb_pkg::WinDepth;
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam int unsigned SelW  = $clog2(Depth);
  localparam logic [FillW-1:0] FillMax = FillW'(Depth);

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  logic [7:0]        kw_q  [NUM_KEYWORDS][Depth];
  logic [4:0]        len_q [NUM_KEYWORDS];
  logic [7:0]        win_q [Depth];
  logic [7:0]        win_n [Depth];
  logic [FillW-1:0]  fill_q, fill_n;
  logic              hit_q, hit_n;
  logic [NUM_KEYWORDS-1:0] kw_hit;

  logic                      out_valid_q;
  hpkb_pkg::verdict_e        verdict_q;
  logic [hpkb_pkg::CountW-1:0] host_q, path_q;
  logic                      out_free;
  logic                      emits;
  logic                      cfg_kw_sel;

  assign cfg_kw_sel = (cfg_index_i < hpkb_pkg::CFG_LENGTHS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        len_q[k] <= '0;
        for (int i = 0; i < Depth; i++) begin
          kw_q[k][i] <= '0;
        end
      end
    end else if (cfg_valid_i) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        if (cfg_kw_sel && cfg_index_i[2:1] == 2'(k)) begin
          for (int i = 0; i < Depth / 2; i++) begin
            if (cfg_index_i[0]) begin
              kw_q[k][i + Depth / 2] <= fold(cfg_data_i[8*i +: 8]);
            end else begin
              kw_q[k][i] <= fold(cfg_data_i[8*i +: 8]);
            end
          end
        end
        if (cfg_index_i == hpkb_pkg::CFG_LENGTHS) begin
          len_q[k] <= (cfg_data_i[5*k +: 5] > hpkb_pkg::MaxWordLen) ?
                      hpkb_pkg::MaxWordLen : cfg_data_i[5*k +: 5];
        end
      end
    end
  end

  always_comb begin
    win_n[0] = fold(head_op_i.data);
    for (int j = 1; j < Depth; j++) begin
      win_n[j] = win_q[j-1];
    end
    if (head_op_i.first) begin
      fill_n = FillW'(1);
    end else if (fill_q == FillMax) begin
      fill_n = fill_q;
    end else begin
      fill_n = fill_q + 1'b1;
    end
  end

  always_comb begin
    logic [SelW-1:0] sel;
    logic [4:0]      off;
    sel = '0;
    off = '0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      kw_hit[k] = (len_q[k] != 5'd0) && (5'(fill_n) >= len_q[k]);
      for (int i = 0; i < Depth; i++) begin
        if (5'(i) < len_q[k]) begin
          off = len_q[k] - 5'd1 - 5'(i);
          sel = off[SelW-1:0];
          if (win_n[sel] != kw_q[k][i]) kw_hit[k] = 1'b0;
        end
      end
    end
    hit_n = ((head_op_i.first) ? 1'b0 : hit_q) | (|kw_hit);
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emits    = (head_op_i.emit != hpkb_pkg::EMIT_NONE);
  assign pop_o    = head_valid_i && (!emits || out_free);

  always_ff @(posedge clk_i) begin
    if (pop_o && head_op_i.byte_en) begin
      for (int j = 0; j < Depth; j++) begin
        win_q[j] <= win_n[j];
      end
    end
    if (pop_o && emits) begin
      host_q <= head_op_i.host_len;
      path_q <= head_op_i.path_len;
      if (head_op_i.emit == hpkb_pkg::EMIT_MALFORMED) begin
        verdict_q <= hpkb_pkg::VERDICT_MALFORMED;
      end else begin
        verdict_q <= hit_q ? hpkb_pkg::VERDICT_BLOCKED : hpkb_pkg::VERDICT_ALLOWED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && head_op_i.byte_en) begin
        fill_q <= fill_n;
        hit_q  <= hit_n;
      end
      if (pop_o && emits) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign host_length_o = host_q;
  assign path_length_o = path_q;

endmodule

`default_nettype wire

// ===== hw/rtl/http_path_keyword_blocker.sv =====
// Top level of the HTTP path keyword blocker: parser, queue and matcher.
//
// Input channel: one request byte per word on in_valid_i/in_ready_o, with
// start_of_request_i marking the first byte and end_of_request_i the last.
// Output channel: one verdict word (allowed, blocked or malformed) with the
// host and path lengths on out_valid_o/out_ready_i, issued when the space
// that ends the path arrives or when a request ends early.
// Configuration: cfg_valid_i/cfg_ready_o writes keyword bytes (index 0..5)
// and the packed keyword lengths (index 6); cfg_ready_o is always high.
// Throughput: one byte per cycle while the queue has room; the window compare
// is combinational. A verdict passes through the queue register and then the
// output register before it shows on out_valid_o.
// Reset clears the parse state, keywords and lengths; the queue empties.
// When the receiver stalls, the output register holds its word, the two-entry
// queue fills, and in_ready_o drops until the verdict is taken.
`default_nettype none

module http_path_keyword_blocker #(
  parameter int unsigned NUM_KEYWORDS = hpkb_pkg::NumKeywords
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    start_of_request_i,
  input  wire logic                    end_of_request_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   verdict_o,
  output logic [hpkb_pkg::CountW-1:0]  host_length_o,
  output logic [hpkb_pkg::CountW-1:0]  path_length_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [2:0]              cfg_index_i,
  input  wire logic [63:0]             cfg_data_i
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  hpkb_pkg::op_t push_op;
  hpkb_pkg::op_t head_op;

  assign cfg_ready_o = 1'b1;

  hpkb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_of_request_i (start_of_request_i),
    .end_of_request_i   (end_of_request_i),
    .full_i             (full),
    .push_o             (push),
    .push_op_o          (push_op)
  );

  hpkb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op)
  );

  hpkb_back #(
    .NUM_KEYWORDS (NUM_KEYWORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .head_valid_i  (head_valid),
    .head_op_i     (head_op),
    .pop_o         (pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .verdict_o     (verdict_o),
    .host_length_o (host_length_o),
    .path_length_o (path_length_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hpkb_checker.sv =====
// Port checks for the HTTP path keyword blocker, bound to the top level.
`default_nettype none

module hpkb_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [1:0]             verdict_o,
  input wire logic [hpkb_pkg::CountW-1:0] host_length_o,
  input wire logic [hpkb_pkg::CountW-1:0] path_length_o
);

  out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  out_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(verdict_o) && $stable(host_length_o) && $stable(path_length_o))
    else $error("output word changed while stalled");

  path_seen_on_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != 2'(hpkb_pkg::VERDICT_MALFORMED) |->
      path_length_o != '0)
    else $error("allowed or blocked verdict without a path byte");

  quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("block not quiet during reset");

endmodule

bind http_path_keyword_blocker hpkb_checker u_checker (.*);

`default_nettype wire
